FILE: hw/rtl/lmps_pkg.sv
// Shared sizes, request/response structs and scan sequencer codes for the
// LED matrix PWM scanner. No dependencies.
`default_nettype none

package lmps_pkg;

    // Matrix geometry and brightness depth
    localparam int ROWS    = 8;
    localparam int COLUMNS = 8;
    localparam int LEVELS  = 4;

    // Fixed field widths of the request and response
    localparam int IDX_W = 6;
    localparam int LVL_W = 3;
    localparam int SEL_W = 3;
    localparam int ROW_W = 8;

    // Derived widths
    localparam int COL_W    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PH_W     = $clog2(LEVELS);
    localparam int CMP_W    = (PH_W > LVL_W) ? PH_W : LVL_W;
    localparam int OUT_ROWS = (ROWS < ROW_W) ? ROWS : ROW_W;

    // Request mode codes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Scan sequencer states, one-hot
    typedef enum logic [2:0] {
        SCAN_COUNT  = 3'b001,
        SCAN_BLANK  = 3'b010,
        SCAN_COLUMN = 3'b100
    } t_scan_state;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] led_addr;
        logic [LVL_W-1:0] brightness;
    } t_in_req;

    typedef struct packed {
        logic [SEL_W-1:0] column_select;
        logic [ROW_W-1:0] row_drive;
    } t_out_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/lmps_level_bank.sv
// Brightness storage for one matrix row: one level per column, cleared at
// reset, one write port and one read port. Depends on lmps_pkg.
`default_nettype none

module lmps_level_bank
    import lmps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [COL_W-1:0] i_wr_col,
    input  wire logic [LVL_W-1:0] i_wr_level,
    input  wire logic [COL_W-1:0] i_rd_col,
    output logic      [LVL_W-1:0] o_level
);

    logic [LVL_W-1:0] r_level [COLUMNS];

    // Store a level, clear all LEDs to off at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < COLUMNS; c++) begin
                r_level[c] <= '0;
            end
        end else if (i_wr_en) begin
            r_level[i_wr_col] <= i_wr_level;
        end
    end

    // Read the level of the addressed column
    assign o_level = r_level[i_rd_col];

endmodule

`default_nettype wire

FILE: hw/rtl/lmps_scan_ctrl.sv
// Scan sequencer: PWM phase counter, blanking and column stepping, and the
// per-row brightness compare. Depends on lmps_pkg.
`default_nettype none

module lmps_scan_ctrl
    import lmps_pkg::*;
(
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_tick,
    input  wire logic [OUT_ROWS-1:0][LVL_W-1:0]  i_levels,
    output logic      [COL_W-1:0]                o_rd_col,
    output t_out_rsp                             o_next
);

    t_scan_state      r_scan, n_scan;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_rows, n_rows;
    logic [COL_W:0]   col_inc;
    logic [COL_W-1:0] col_wrap;
    logic [PH_W-1:0]  phase_inc;
    logic             col_step;
    logic [COL_W-1:0] eval_col;
    logic [PH_W-1:0]  eval_phase;
    logic [ROW_W-1:0] eval_rows;

    assign col_inc   = {1'b0, r_col} + 1'b1;
    assign col_wrap  = (col_inc >= (COL_W+1)'(COLUMNS)) ? '0 : col_inc[COL_W-1:0];
    assign phase_inc = r_phase + 1'b1;

    // Pick the column and phase that the rows of this tick are lit at
    assign col_step   = (r_scan == SCAN_COLUMN);
    assign eval_col   = (i_tick && col_step) ? col_wrap : r_col;
    assign eval_phase = col_step ? r_phase : phase_inc;

    // Step the sequencer on a tick, hold otherwise
    always_comb begin
        n_scan  = r_scan;
        n_phase = r_phase;
        n_col   = r_col;
        n_rows  = r_rows;
        if (i_tick) begin
            unique case (r_scan)
                SCAN_BLANK: begin
                    n_phase = '0;
                    n_rows  = '0;
                    n_scan  = SCAN_COLUMN;
                end
                SCAN_COLUMN: begin
                    n_col  = col_wrap;
                    n_scan = SCAN_COUNT;
                    n_rows = eval_rows;
                end
                default: begin
                    n_phase = phase_inc;
                    n_scan  = (phase_inc >= PH_W'(LEVELS - 1)) ? SCAN_BLANK : SCAN_COUNT;
                    n_rows  = eval_rows;
                end
            endcase
        end
    end

    // Light a row when the phase is below its LED level
    always_comb begin
        eval_rows = '0;
        for (int r = 0; r < OUT_ROWS; r++) begin
            eval_rows[r] = CMP_W'(eval_phase) < CMP_W'(i_levels[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= SCAN_COUNT;
            r_phase <= '0;
            r_col   <= '0;
            r_rows  <= '0;
        end else begin
            r_scan  <= n_scan;
            r_phase <= n_phase;
            r_col   <= n_col;
            r_rows  <= n_rows;
        end
    end

    // Levels are read at the column that the tick moves to
    assign o_rd_col             = eval_col;
    assign o_next.column_select = SEL_W'(n_col);
    assign o_next.row_drive     = n_rows;

endmodule

`default_nettype wire

FILE: hw/rtl/led_matrix_pwm_scanner.sv
// LED matrix column scanner with per-LED PWM brightness.
// The response to a request is registered and valid in the cycle after it is accepted.
// Throughput: one request per cycle while the output is not stalled; the result
// register and the state update together, and a request is taken whenever the
// result register is empty or drained in the same cycle.
// Reset (synchronous, active low) clears every LED level, the scan state and
// the result valid flag at once; no clearing pass.
`default_nettype none

module led_matrix_pwm_scanner
    import lmps_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_req  i_in_req,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_rsp      o_out_rsp
);

    logic                           accept;
    logic                           tick;
    logic                           wr;
    logic [COL_W-1:0]               rd_col;
    logic [OUT_ROWS-1:0][LVL_W-1:0] levels;
    t_out_rsp                       next_rsp;
    logic                           r_out_valid;
    t_out_rsp                       r_out_rsp;

    // Take a request when the result slot is free or drains this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign tick       = accept && (i_in_req.mode == MODE_TICK);
    assign wr         = accept && (i_in_req.mode == MODE_WRITE);

    // One storage bank per visible row; decode the write into row and column
    for (genvar r = 0; r < OUT_ROWS; r++) begin : g_row
        logic [IDX_W:0]   offset;
        logic             in_row;

        assign offset = {1'b0, i_in_req.led_addr} - (IDX_W+1)'(r * COLUMNS);
        assign in_row = ({1'b0, i_in_req.led_addr} >= (IDX_W+1)'(r * COLUMNS))
                     && (offset < (IDX_W+1)'(COLUMNS));

        lmps_level_bank u_bank (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (wr && in_row),
            .i_wr_col   (offset[COL_W-1:0]),
            .i_wr_level (i_in_req.brightness),
            .i_rd_col   (rd_col),
            .o_level    (levels[r])
        );
    end

    lmps_scan_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_levels (levels),
        .o_rd_col (rd_col),
        .o_next   (next_rsp)
    );

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_rsp <= next_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire
